FILE: rtl/sorted_four_slot_key_table_unit_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the sorted key table
// same-cycle implication and next-cycle implication, both reset-qualified
// ---------------------------------------------------------------------------
`ifndef SORTED_FOUR_SLOT_KEY_TABLE_UNIT_ASSERT_SVH
`define SORTED_FOUR_SLOT_KEY_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SFKT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfkt assertion failed");
// antecedent implies consequent in the next cycle
`define SFKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfkt assertion failed");
`else
`define SFKT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFKT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/sfkt_pkg.sv
// ---------------------------------------------------------------------------
// sfkt_pkg
// request codes, status codes and the result control bundle
// ---------------------------------------------------------------------------
package sfkt_pkg;

    // request codes
    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_LOOKUP = 3'd1,
        REQ_CHANGE = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_OTHER  = 3'd4,
        REQ_RANGE  = 3'd5
    } t_req_type;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // control part of one result
    typedef struct packed {
        t_status status;
        logic    last;
    } t_res_ctl;

endpackage

FILE: rtl/sfkt_req_reg.sv
// ---------------------------------------------------------------------------
// sfkt_req_reg
// input register: holds one request until the engine takes it
// ---------------------------------------------------------------------------
module sfkt_req_reg #(
    parameter int CHILD_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_req_type,
    input  logic [7:0]            i_key,
    input  logic [7:0]            i_key_hi,
    input  logic [CHILD_BITS-1:0] i_child_ref,
    input  logic                  i_take,
    output logic                  o_valid,
    output logic [2:0]            o_req_type,
    output logic [7:0]            o_key,
    output logic [7:0]            o_key_hi,
    output logic [CHILD_BITS-1:0] o_child_ref
);
    import sfkt_pkg::*;

    logic                  r_valid;
    logic [2:0]            r_req_type;
    logic [7:0]            r_key;
    logic [7:0]            r_key_hi;
    logic [CHILD_BITS-1:0] r_child_ref;
    logic                  n_valid;
    logic                  accept;

    // hold off a new transfer only while the held request is not taken
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type  <= i_req_type;
            r_key       <= i_key;
            r_key_hi    <= i_key_hi;
            r_child_ref <= i_child_ref;
        end
    end

    assign o_valid     = r_valid;
    assign o_req_type  = r_req_type;
    assign o_key       = r_key;
    assign o_key_hi    = r_key_hi;
    assign o_child_ref = r_child_ref;

endmodule

FILE: rtl/sfkt_engine.sv
`include "sorted_four_slot_key_table_unit_assert.svh"
// ---------------------------------------------------------------------------
// sfkt_engine
// slot storage, parallel key compare, sorted insert and remove shifts,
// and the range list walker
// ---------------------------------------------------------------------------
module sfkt_engine #(
    parameter int SLOTS      = 4,
    parameter int CHILD_BITS = 48,
    parameter int OCC_W      = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic [2:0]            i_req_type,
    input  logic [7:0]            i_key,
    input  logic [7:0]            i_key_hi,
    input  logic [CHILD_BITS-1:0] i_child_ref,
    output logic                  o_req_take,
    input  logic                  i_out_free,
    output logic                  o_res_valid,
    output sfkt_pkg::t_res_ctl    o_res_ctl,
    output logic [7:0]            o_res_key,
    output logic [CHILD_BITS-1:0] o_res_child,
    output logic [OCC_W-1:0]      o_res_occ
);
    import sfkt_pkg::*;

    // slot storage, no reset: only slots below the fill count are read
    logic [7:0]            r_keys     [SLOTS];
    logic [CHILD_BITS-1:0] r_children [SLOTS];
    logic [OCC_W-1:0]      r_used;
    logic [OCC_W-1:0]      n_used;
    logic [SLOTS-1:0]      r_list_mask;
    logic [SLOTS-1:0]      n_list_mask;

    logic                  list_busy;
    logic                  full;
    logic                  ins_write;
    logic                  chg_write;
    logic                  rem_write;
    logic [SLOTS-1:0]      v_valid;
    logic [SLOTS-1:0]      v_lt;
    logic [SLOTS-1:0]      v_eq;
    logic [SLOTS-1:0]      v_ne;
    logic [SLOTS-1:0]      v_rng;
    logic [SLOTS-1:0]      lt_prev;
    logic [SLOTS-1:0]      eq_first;
    logic [SLOTS-1:0]      ne_first;
    logic [SLOTS-1:0]      after;
    logic [SLOTS-1:0]      src;
    logic [SLOTS-1:0]      pick;
    logic [SLOTS-1:0]      rest;
    logic [CHILD_BITS-1:0] eq_child;
    logic [7:0]            ne_key;
    logic [CHILD_BITS-1:0] ne_child;
    logic [7:0]            pick_key;
    logic [CHILD_BITS-1:0] pick_child;

    assign list_busy  = |r_list_mask;
    assign full       = (r_used == OCC_W'(SLOTS));
    assign o_req_take = i_req_valid && i_out_free && !list_busy;

    // per-slot compares against the request key
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            v_valid[i] = OCC_W'(i) < r_used;
            v_lt[i]    = v_valid[i] && (r_keys[i] < i_key);
            v_eq[i]    = v_valid[i] && (r_keys[i] == i_key);
            v_ne[i]    = v_valid[i] && (r_keys[i] != i_key);
            v_rng[i]   = v_valid[i] && (r_keys[i] >= i_key) && (r_keys[i] <= i_key_hi);
        end
    end

    // lowest-slot picks
    assign lt_prev  = {v_lt[SLOTS-2:0], 1'b1};
    assign eq_first = v_eq & (~v_eq + SLOTS'(1));
    assign ne_first = v_ne & (~v_ne + SLOTS'(1));
    assign after    = ~(eq_first - SLOTS'(1));
    assign src      = list_busy ? r_list_mask : v_rng;
    assign pick     = src & (~src + SLOTS'(1));
    assign rest     = src & ~pick;

    // one-hot entry selection
    always_comb begin
        eq_child   = '0;
        ne_key     = '0;
        ne_child   = '0;
        pick_key   = '0;
        pick_child = '0;
        for (int i = 0; i < SLOTS; i++) begin
            eq_child   = eq_child   | ({CHILD_BITS{eq_first[i]}} & r_children[i]);
            ne_key     = ne_key     | ({8{ne_first[i]}} & r_keys[i]);
            ne_child   = ne_child   | ({CHILD_BITS{ne_first[i]}} & r_children[i]);
            pick_key   = pick_key   | ({8{pick[i]}} & r_keys[i]);
            pick_child = pick_child | ({CHILD_BITS{pick[i]}} & r_children[i]);
        end
    end

    assign ins_write = o_req_take && (i_req_type == REQ_INSERT) && !full;
    assign chg_write = o_req_take && (i_req_type == REQ_CHANGE) && (|v_eq);
    assign rem_write = o_req_take && (i_req_type == REQ_REMOVE) && (|v_eq);

    // result and next fill count
    always_comb begin
        o_res_valid       = 1'b0;
        o_res_ctl.status  = ST_OK;
        o_res_ctl.last    = 1'b1;
        o_res_key         = '0;
        o_res_child       = '0;
        n_used            = r_used;
        n_list_mask       = r_list_mask;
        if (list_busy) begin
            // continue a range list
            if (i_out_free) begin
                o_res_valid    = 1'b1;
                o_res_key      = pick_key;
                o_res_child    = pick_child;
                o_res_ctl.last = ~|rest;
                n_list_mask    = rest;
            end
        end else if (o_req_take) begin
            unique case (i_req_type) inside
                REQ_INSERT: begin
                    o_res_valid = 1'b1;
                    o_res_key   = i_key;
                    if (full) begin
                        o_res_ctl.status = ST_FULL;
                    end else begin
                        o_res_child = i_child_ref;
                        n_used      = r_used + OCC_W'(1);
                    end
                end
                REQ_LOOKUP, REQ_CHANGE, REQ_REMOVE: begin
                    o_res_valid = 1'b1;
                    o_res_key   = i_key;
                    if (!(|v_eq)) begin
                        o_res_ctl.status = ST_NOT_FOUND;
                    end else begin
                        o_res_child = (i_req_type == REQ_CHANGE) ? i_child_ref : eq_child;
                        if (i_req_type == REQ_REMOVE) begin
                            n_used = r_used - OCC_W'(1);
                        end
                    end
                end
                REQ_OTHER: begin
                    o_res_valid = 1'b1;
                    if (!(|v_ne)) begin
                        o_res_ctl.status = ST_NOT_FOUND;
                    end else begin
                        o_res_key   = ne_key;
                        o_res_child = ne_child;
                    end
                end
                REQ_RANGE: begin
                    o_res_valid = 1'b1;
                    if (!(|v_rng)) begin
                        o_res_ctl.status = ST_EMPTY;
                    end else begin
                        o_res_key      = pick_key;
                        o_res_child    = pick_child;
                        o_res_ctl.last = ~|rest;
                        n_list_mask    = rest;
                    end
                end
                default: begin
                    // unknown codes are dropped without a result
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    assign o_res_occ = n_used;

    // fill count and range walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_list_mask <= '0;
        end else begin
            r_used      <= n_used;
            r_list_mask <= n_list_mask;
        end
    end

    // per-slot update: insert shifts up, remove shifts down, change rewrites
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        logic [7:0]            prev_key;
        logic [CHILD_BITS-1:0] prev_child;
        logic [7:0]            next_key;
        logic [CHILD_BITS-1:0] next_child;
        logic [7:0]            n_key;
        logic [CHILD_BITS-1:0] n_child;

        if (g == 0) begin : g_first
            assign prev_key   = i_key;
            assign prev_child = i_child_ref;
        end else begin : g_mid
            assign prev_key   = r_keys[g-1];
            assign prev_child = r_children[g-1];
        end

        if (g == SLOTS - 1) begin : g_top
            assign next_key   = r_keys[g];
            assign next_child = r_children[g];
        end else begin : g_below
            assign next_key   = r_keys[g+1];
            assign next_child = r_children[g+1];
        end

        always_comb begin
            n_key   = r_keys[g];
            n_child = r_children[g];
            if (ins_write && !v_lt[g]) begin
                n_key   = lt_prev[g] ? i_key : prev_key;
                n_child = lt_prev[g] ? i_child_ref : prev_child;
            end else if (chg_write && eq_first[g]) begin
                n_child = i_child_ref;
            end else if (rem_write && after[g]) begin
                n_key   = next_key;
                n_child = next_child;
            end
        end

        always_ff @(posedge i_clk) begin
            r_keys[g]     <= n_key;
            r_children[g] <= n_child;
        end
    end

    // checks
    `SFKT_ASSERT_SAME(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= OCC_W'(SLOTS))
    `SFKT_ASSERT_SAME(a_res_needs_room, i_clk, i_rst_n, o_res_valid, i_out_free)
    `SFKT_ASSERT_SAME(a_no_take_in_list, i_clk, i_rst_n, list_busy, !o_req_take)

endmodule

FILE: rtl/sorted_four_slot_key_table_unit.sv
// One request transfer is taken per clock while the output side keeps up:
// lookup, insert, change, remove and other-entry requests each give one
// result, produced by the engine and held in an output register, so a new
// request follows every cycle while the output side keeps up. A range list
// gives one result per matching entry, one per cycle while the output side
// keeps up, and the engine takes no further request until its last entry
// has left; the table contents are frozen for that time. Keys are kept
// sorted in slots below the occupancy count, which is cleared at reset with
// the valid flags and the range list mask; no clearing pass is needed.
`include "sorted_four_slot_key_table_unit_assert.svh"
// ---------------------------------------------------------------------------
// sorted_four_slot_key_table_unit
// sorted key table with request register, engine and result register
// ---------------------------------------------------------------------------
module sorted_four_slot_key_table_unit #(
    parameter int  SLOTS      = 4,
    parameter int  CHILD_BITS = 48,
    localparam int OCC_W      = $clog2(SLOTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_req_type,
    input  logic [7:0]            i_key,
    input  logic [7:0]            i_key_hi,
    input  logic [CHILD_BITS-1:0] i_child_ref,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [7:0]            o_out_key,
    output logic [CHILD_BITS-1:0] o_out_child,
    output logic [OCC_W-1:0]      o_occupancy,
    output logic                  o_last
);
    import sfkt_pkg::*;

    logic                  req_valid;
    logic [2:0]            req_type;
    logic [7:0]            req_key;
    logic [7:0]            req_key_hi;
    logic [CHILD_BITS-1:0] req_child;
    logic                  req_take;
    logic                  out_free;
    logic                  res_valid;
    t_res_ctl              res_ctl;
    logic [7:0]            res_key;
    logic [CHILD_BITS-1:0] res_child;
    logic [OCC_W-1:0]      res_occ;

    logic                  r_out_valid;
    t_res_ctl              r_out_ctl;
    logic [7:0]            r_out_key;
    logic [CHILD_BITS-1:0] r_out_child;
    logic [OCC_W-1:0]      r_out_occ;

    // request register
    sfkt_req_reg #(
        .CHILD_BITS (CHILD_BITS)
    ) u_req_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_key       (i_key),
        .i_key_hi    (i_key_hi),
        .i_child_ref (i_child_ref),
        .i_take      (req_take),
        .o_valid     (req_valid),
        .o_req_type  (req_type),
        .o_key       (req_key),
        .o_key_hi    (req_key_hi),
        .o_child_ref (req_child)
    );

    // table engine
    sfkt_engine #(
        .SLOTS      (SLOTS),
        .CHILD_BITS (CHILD_BITS),
        .OCC_W      (OCC_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req_type  (req_type),
        .i_key       (req_key),
        .i_key_hi    (req_key_hi),
        .i_child_ref (req_child),
        .o_req_take  (req_take),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res_ctl   (res_ctl),
        .o_res_key   (res_key),
        .o_res_child (res_child),
        .o_res_occ   (res_occ)
    );

    // result register frees when empty or when its transfer completes
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_ctl   <= res_ctl;
            r_out_key   <= res_key;
            r_out_child <= res_child;
            r_out_occ   <= res_occ;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_ctl.status;
    assign o_last      = r_out_ctl.last;
    assign o_out_key   = r_out_key;
    assign o_out_child = r_out_child;
    assign o_occupancy = r_out_occ;

    // checks
    `SFKT_ASSERT_SAME(a_occ_bound, i_clk, i_rst_n, r_out_valid, r_out_occ <= OCC_W'(SLOTS))
    `SFKT_ASSERT_SAME(a_list_ok, i_clk, i_rst_n,
                      r_out_valid && !r_out_ctl.last, r_out_ctl.status == ST_OK)
    `SFKT_ASSERT_NEXT(a_list_cont, i_clk, i_rst_n,
                      r_out_valid && !r_out_ctl.last && !i_out_stall, r_out_valid)

endmodule
